>>> sv/tss_pkg.sv
// Shared types, codes and widths for the triangular sweep sequencer.
// No dependencies; used by tss_divider and triangular_sweep_sequencer.

package tss_pkg;

  // Field widths
  localparam int unsigned MvW      = 14;  // configured and reported millivolts
  localparam int unsigned VoltW    = 15;  // running sweep voltage
  localparam int unsigned SumW     = 16;  // voltage arithmetic headroom
  localparam int unsigned StepW    = 10;
  localparam int unsigned CodeW    = 16;  // DAC codes and divider quotient
  localparam int unsigned CntW     = 10;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ProdW    = MvW + CodeW;  // span offset times full code
  localparam int unsigned DivSteps = CodeW;        // one quotient bit per step
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  // Register reset values
  localparam logic signed [MvW-1:0] LowReset   = -14'sd1000;
  localparam logic signed [MvW-1:0] HighReset  = 14'sd1000;
  localparam logic [StepW-1:0]      StepReset  = 10'd10;
  localparam logic [CodeW-1:0]      FullReset  = 16'd65535;
  localparam logic [CodeW-1:0]      ParkReset  = 16'd32768;
  localparam logic [CntW-1:0]       LimitReset = 10'd400;

  // Input item kinds
  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_STOP  = 2'd1,
    MODE_TICK  = 2'd2
  } mode_e;

  // Bus action reported per result
  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_DAC_WRITE = 2'd1,
    ACT_ADC_START = 2'd2,
    ACT_ADC_READ  = 2'd3
  } action_e;

  // Three-tick point cycle
  typedef enum logic [1:0] {
    PH_WRITE = 2'd0,
    PH_START = 2'd1,
    PH_READ  = 2'd2
  } phase_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW   = 3'd0,
    CFG_HIGH  = 3'd1,
    CFG_STEP  = 3'd2,
    CFG_FULL  = 3'd3,
    CFG_PARK  = 3'd4,
    CFG_LIMIT = 3'd5
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_LOAD = 2'd2,
    ST_DIV  = 2'd3
  } state_e;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> sv/tss_divider.sv
// Serial restoring divider: one quotient bit per clock, for the DAC code mapping.
// Depends on tss_pkg for widths and the status struct.

module tss_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tss_pkg::ProdW-1:0]     dividend_i,
  input  logic [tss_pkg::MvW-1:0]       divisor_i,
  output tss_pkg::div_stat_t            stat_o,
  output logic [tss_pkg::CodeW-1:0]     quotient_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [tss_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic [tss_pkg::MvW-1:0]       rem_q, rem_d;
  logic [tss_pkg::MvW-1:0]       den_q, den_d;
  logic [tss_pkg::CodeW-1:0]     sh_q, sh_d;
  logic [tss_pkg::MvW:0]         trial;
  logic                          fits;

  // Trial subtract of the divisor from the shifted remainder
  assign trial = {rem_q, sh_q[tss_pkg::CodeW-1]};
  assign fits  = trial >= {1'b0, den_q};

  // Load on start, then shift one bit per cycle; the quotient fills sh_q
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    sh_d   = sh_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = tss_pkg::DivCntW'(tss_pkg::DivSteps);
      rem_d  = dividend_i[tss_pkg::ProdW-1:tss_pkg::CodeW];
      sh_d   = dividend_i[tss_pkg::CodeW-1:0];
      den_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? tss_pkg::MvW'(trial - {1'b0, den_q}) : trial[tss_pkg::MvW-1:0];
      sh_d  = {sh_q[tss_pkg::CodeW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == tss_pkg::DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath holds no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    sh_q  <= sh_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = sh_q;

endmodule

>>> sv/triangular_sweep_sequencer.sv
// Top level of the triangular sweep sequencer: control state, sweep update,
// DAC code mapping sequence and result register. Depends on tss_pkg, tss_divider.

// Each input transaction (start, stop or tick) yields one result transaction.
// Start, stop, ADC start and ADC read ticks, idle ticks, failed DAC write ticks
// and DAC write ticks with the high voltage not above the low one are settled in
// the accepting cycle, and their result is visible on the next cycle. A
// successful DAC write tick with the high voltage above the low one maps the
// voltage to a code by one 14x16 multiply and a 16-step serial divide, so its
// result is registered after the ST_MUL, ST_LOAD and ST_DIV states. The
// input side takes a new transaction once the sequencer is idle and the result
// register is empty or being emptied. Configuration writes are registered directly
// and are meant to happen while no transaction is in flight.

module triangular_sweep_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [tss_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tss_pkg::CfgDataW-1:0]   cfg_data_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     mode_i,
  input  logic                           access_ok_i,
  input  logic signed [tss_pkg::SampleW-1:0] adc_sample_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     action_o,
  output logic [tss_pkg::CodeW-1:0]      dac_code_o,
  output logic                           point_valid_o,
  output logic [tss_pkg::CntW-1:0]       point_index_o,
  output logic signed [tss_pkg::MvW-1:0] point_mv_o,
  output logic signed [tss_pkg::SampleW-1:0] point_current_o,
  output logic                           park_dac_o,
  output logic                           fault_o,
  output logic                           start_rejected_o,
  output logic                           busy_res_o,
  output logic [tss_pkg::CntW-1:0]       points_taken_o
);

  localparam int unsigned SumW = tss_pkg::SumW;

  // Configuration registers
  logic signed [tss_pkg::MvW-1:0] low_q, high_q;
  logic [tss_pkg::StepW-1:0]      step_q;
  logic [tss_pkg::CodeW-1:0]      full_q, park_q;
  logic [tss_pkg::CntW-1:0]       limit_q;

  // Sweep state
  logic                           running_q, running_d;
  tss_pkg::phase_e                phase_q, phase_d;
  logic signed [tss_pkg::VoltW-1:0] v_q, v_d;
  logic                           falling_q, falling_d;
  logic [tss_pkg::CntW-1:0]       cnt_q, cnt_d;

  // Sequencer
  tss_pkg::state_e                state_q, state_d;
  logic                           in_acc;
  logic                           div_start;
  tss_pkg::div_stat_t             div_stat;
  logic [tss_pkg::CodeW-1:0]      quotient;
  logic [tss_pkg::MvW-1:0]        diff_q, den_q;
  logic [tss_pkg::ProdW-1:0]      prod_q;
  logic                           out_valid_q, set_out;

  // Per-transaction decode
  tss_pkg::action_e               act;
  logic                           pvalid, park, fault, rej, need_div, end_sweep;
  logic [tss_pkg::CntW-1:0]       pidx;
  logic signed [tss_pkg::MvW-1:0] pmv;
  logic signed [tss_pkg::SampleW-1:0] pcur;

  // Voltage arithmetic
  logic signed [SumW-1:0]         lo16, hi16, v16, step16, v_sum, vc16, diff16, span16;
  logic                           span_pos;

  // Result register payload
  logic [1:0]                     action_q;
  logic [tss_pkg::CodeW-1:0]      dac_q;
  logic                           pvalid_q, park_res_q, fault_q, rej_q, busy_q;
  logic [tss_pkg::CntW-1:0]       pidx_q, taken_q;
  logic signed [tss_pkg::MvW-1:0] pmv_q;
  logic signed [tss_pkg::SampleW-1:0] pcur_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q   <= tss_pkg::LowReset;
      high_q  <= tss_pkg::HighReset;
      step_q  <= tss_pkg::StepReset;
      full_q  <= tss_pkg::FullReset;
      park_q  <= tss_pkg::ParkReset;
      limit_q <= tss_pkg::LimitReset;
    end else if (cfg_we_i) begin
      unique case (tss_pkg::cfg_idx_e'(cfg_index_i))
        tss_pkg::CFG_LOW:   low_q   <= $signed(cfg_data_i[tss_pkg::MvW-1:0]);
        tss_pkg::CFG_HIGH:  high_q  <= $signed(cfg_data_i[tss_pkg::MvW-1:0]);
        tss_pkg::CFG_STEP:  step_q  <= cfg_data_i[tss_pkg::StepW-1:0];
        tss_pkg::CFG_FULL:  full_q  <= cfg_data_i;
        tss_pkg::CFG_PARK:  park_q  <= cfg_data_i;
        tss_pkg::CFG_LIMIT: limit_q <= cfg_data_i[tss_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  // Extend voltages and form the next sweep voltage and the mapping operands
  always_comb begin
    lo16     = SumW'(low_q);
    hi16     = SumW'(high_q);
    v16      = SumW'(v_q);
    step16   = $signed(SumW'(step_q));
    v_sum    = falling_q ? v16 - step16 : v16 + step16;
    span_pos = hi16 > lo16;
    if (v16 < lo16) begin
      vc16 = lo16;
    end else if (v16 > hi16) begin
      vc16 = hi16;
    end else begin
      vc16 = v16;
    end
    diff16 = vc16 - lo16;
    span16 = hi16 - lo16;
  end

  // Decode one transaction: result fields and next sweep state
  always_comb begin
    running_d  = running_q;
    phase_d    = phase_q;
    v_d        = v_q;
    falling_d  = falling_q;
    cnt_d      = cnt_q;
    act        = tss_pkg::ACT_NONE;
    pvalid     = 1'b0;
    pidx       = '0;
    pmv        = '0;
    pcur       = '0;
    park       = 1'b0;
    fault      = 1'b0;
    rej        = 1'b0;
    need_div   = 1'b0;
    end_sweep  = 1'b0;
    unique case (tss_pkg::mode_e'(mode_i))
      tss_pkg::MODE_START: begin
        if (running_q) begin
          rej = 1'b1;
        end else begin
          v_d       = tss_pkg::VoltW'(low_q);
          falling_d = 1'b0;
          cnt_d     = '0;
          phase_d   = tss_pkg::PH_WRITE;
          running_d = 1'b1;
        end
      end
      tss_pkg::MODE_STOP: begin
        if (running_q) begin
          running_d = 1'b0;
          park      = 1'b1;
        end
      end
      tss_pkg::MODE_TICK: begin
        if (running_q) begin
          unique case (phase_q)
            tss_pkg::PH_START: begin
              act = tss_pkg::ACT_ADC_START;
              if (!access_ok_i) begin
                park  = 1'b1;
                fault = 1'b1;
              end else begin
                phase_d = tss_pkg::PH_READ;
              end
            end
            tss_pkg::PH_READ: begin
              act = tss_pkg::ACT_ADC_READ;
              if (!access_ok_i) begin
                park  = 1'b1;
                fault = 1'b1;
              end else begin
                // record the point while the limit allows
                if (cnt_q < limit_q) begin
                  pvalid = 1'b1;
                  pidx   = cnt_q;
                  pmv    = v_q[tss_pkg::MvW-1:0];
                  pcur   = adc_sample_i;
                  cnt_d  = cnt_q + 1'b1;
                end
                // advance voltage, reverse at the top, end at the bottom
                if (v_sum >= hi16) begin
                  v_d       = tss_pkg::VoltW'(high_q);
                  falling_d = 1'b1;
                end else begin
                  v_d = v_sum[tss_pkg::VoltW-1:0];
                  if (v_sum <= lo16 && falling_q) begin
                    end_sweep = 1'b1;
                  end
                end
                if (cnt_d >= limit_q) begin
                  end_sweep = 1'b1;
                end
                if (end_sweep) begin
                  park = 1'b1;
                end else begin
                  phase_d = tss_pkg::PH_WRITE;
                end
              end
            end
            default: begin
              // write phase, also taken for the unused phase code
              act = tss_pkg::ACT_DAC_WRITE;
              if (!access_ok_i) begin
                park  = 1'b1;
                fault = 1'b1;
              end else begin
                phase_d  = tss_pkg::PH_START;
                need_div = span_pos;
              end
            end
          endcase
          if (park) begin
            running_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tss_pkg::ST_IDLE: if (in_acc && need_div) state_d = tss_pkg::ST_MUL;
      tss_pkg::ST_MUL:  state_d = tss_pkg::ST_LOAD;
      tss_pkg::ST_LOAD: state_d = tss_pkg::ST_DIV;
      tss_pkg::ST_DIV:  if (div_stat.done) state_d = tss_pkg::ST_IDLE;
      default:          state_d = tss_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o = (state_q == tss_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
    in_acc     = in_valid_i && in_ready_o;
    div_start  = state_q == tss_pkg::ST_LOAD;
    set_out    = (in_acc && !need_div) || (state_q == tss_pkg::ST_DIV && div_stat.done);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tss_pkg::ST_IDLE;
      running_q   <= 1'b0;
      phase_q     <= tss_pkg::PH_WRITE;
      v_q         <= '0;
      falling_q   <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        running_q <= running_d;
        phase_q   <= phase_d;
        v_q       <= v_d;
        falling_q <= falling_d;
        cnt_q     <= cnt_d;
      end
      if (set_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Mapping operands and product; result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      diff_q     <= diff16[tss_pkg::MvW-1:0];
      den_q      <= span16[tss_pkg::MvW-1:0];
      action_q   <= act;
      dac_q      <= park ? park_q : '0;
      pvalid_q   <= pvalid;
      pidx_q     <= pidx;
      pmv_q      <= pmv;
      pcur_q     <= pcur;
      park_res_q <= park;
      fault_q    <= fault;
      rej_q      <= rej;
      busy_q     <= running_d;
      taken_q    <= cnt_d;
    end else if (state_q == tss_pkg::ST_DIV && div_stat.done) begin
      dac_q <= quotient;
    end
    if (state_q == tss_pkg::ST_MUL) begin
      prod_q <= diff_q * full_q;
    end
  end

  tss_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (den_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  assign out_valid_o      = out_valid_q;
  assign action_o         = action_q;
  assign dac_code_o       = dac_q;
  assign point_valid_o    = pvalid_q;
  assign point_index_o    = pidx_q;
  assign point_mv_o       = pmv_q;
  assign point_current_o  = pcur_q;
  assign park_dac_o       = park_res_q;
  assign fault_o          = fault_q;
  assign start_rejected_o = rej_q;
  assign busy_res_o       = busy_q;
  assign points_taken_o   = taken_q;

`ifndef SYNTHESIS
  // Divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == tss_pkg::ST_DIV)
    else $error("divider done outside divide state");

  // A mapped DAC write presents no result right after it is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && need_div) |=> !out_valid_q)
    else $error("result shown before DAC code mapped");

  // A fault always parks the DAC
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fault_o) |-> park_dac_o)
    else $error("fault without park");

  // An ended sweep is not reported as running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(park_dac_o && busy_res_o))
    else $error("park while still running");

  // Points come only from ADC read ticks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && point_valid_o) |-> action_o == tss_pkg::ACT_ADC_READ)
    else $error("point recorded outside read tick");
`endif

endmodule
